/* hw/rtl/assert_macros.svh */
// assertion macros used by the report differ top level
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, disabled during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// overlapping implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/hkrd_pkg.sv */
// shared types and constants of the keyboard report differ
// no dependencies
`timescale 1ns / 1ps

package hkrd_pkg;

    localparam int KEY_SLOTS_DEF = 6;
    localparam int CODE_WIDTH    = 8;

    localparam logic [CODE_WIDTH-1:0] CODE_NONE        = 8'h00;
    localparam logic [CODE_WIDTH-1:0] CODE_NEVER_MATCH = 8'h01;
    localparam logic [CODE_WIDTH-1:0] CODE_CAPS        = 8'h39;
    localparam logic [CODE_WIDTH-1:0] CODE_NUM         = 8'h53;
    localparam logic [CODE_WIDTH-1:0] CODE_SCROLL      = 8'h47;

    typedef enum logic [1:0] {
        KIND_MOD  = 2'd0,
        KIND_DOWN = 2'd1,
        KIND_UP   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

/* hw/rtl/hid_keyboard_report_differ.sv */
// top level of the boot keyboard report differ: sequencer, report store, output register
// depends on hkrd_pkg, hkrd_match and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one boot keyboard report per transaction (modifier byte and KEY_SLOTS key codes)
// and turns its difference to the previous report into a run of event transactions:
// a modifier change first if the byte changed, then per slot in order a key down for a
// new code and a key up for a code that went away; m_tlast marks the final event of the
// report, and a report equal to the previous one gives no events unless a slot holds code
// 8'h01, which never matches. A single 8-bit code comparator does all key matching, one
// compare per cycle; s_tready stays low while a report is matched and its events are output,
// until the output pass has gone through every event position of the report.
// Lock keys toggle their lock bits as they are pressed, a caps lock press that turns the lock
// off is reported as a key up, and caps lock releases are never reported. The event kind
// travels on m_tuser.
module hid_keyboard_report_differ
#(
    parameter int KEY_SLOTS = hkrd_pkg::KEY_SLOTS_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // modifiers, key_slot_0 .. key_slot_(KEY_SLOTS-1), 8 bits each
    input  logic [(KEY_SLOTS+1)*hkrd_pkg::CODE_WIDTH-1:0] s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // current_modifiers[7:0], earlier_modifiers[15:8], key_code[23:16],
    // caps_lock_on[24], num_lock_on[25], scroll_lock_on[26], zero fill
    output logic [31:0]                                 m_tdata,
    // event_kind[1:0]
    output logic [1:0]                                  m_tuser,
    // last_event
    output logic                                        m_tlast
);

    localparam int CW = hkrd_pkg::CODE_WIDTH;
    localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    // event positions: modifier event, then a down and an up place per slot
    localparam int NE = 2 * KEY_SLOTS + 1;
    localparam int PW = $clog2(NE + 1);

    // sequencer
    hkrd_pkg::state_t state_reg, state_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          side_reg, side_next;   // 0 held search, 1 kept search
    logic [PW-1:0] pos_reg, pos_next;

    // report store
    logic [CW-1:0] cur_mod_reg;
    logic [CW-1:0] cur_key_reg [KEY_SLOTS];
    logic [CW-1:0] prior_mod_reg, prior_mod_next;
    logic [CW-1:0] prior_key_reg [KEY_SLOTS];
    logic          commit;
    logic [KEY_SLOTS-1:0] held_reg, held_next;
    logic [KEY_SLOTS-1:0] kept_reg, kept_next;

    // lock bits
    logic caps_reg, caps_next;
    logic num_reg, num_next;
    logic scroll_reg, scroll_next;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    hkrd_pkg::kind_t     out_kind_reg, out_kind_next;
    logic [CW-1:0]       out_cur_reg, out_earlier_reg;
    logic [CW-1:0]       out_code_reg, out_code_next;
    logic                out_caps_reg, out_num_reg, out_scroll_reg;
    logic                out_last_reg, out_last_next;
    logic                out_load;

    // shared comparator
    logic [CW-1:0] cmp_a, cmp_b;
    logic          cmp_hit;

    // event bookkeeping
    logic [NE-1:0] evt_vec;
    logic [NE-1:0] evt_rest;
    logic [PW-1:0] pos_m1;
    logic [IW-1:0] evt_slot;
    logic          in_accept;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == hkrd_pkg::ST_IDLE);

    // held: current code of a slot against all prior codes
    // kept: prior code of a slot against all current codes
    assign cmp_a = side_reg ? prior_key_reg[slot_reg] : cur_key_reg[slot_reg];
    assign cmp_b = side_reg ? cur_key_reg[idx_reg]   : prior_key_reg[idx_reg];

    hkrd_match u_match
    (
        .code_a (cmp_a),
        .code_b (cmp_b),
        .hit    (cmp_hit)
    );

    // which event positions produce a transaction for this report
    always_comb
    begin
        evt_vec[0] = (cur_mod_reg != prior_mod_reg);
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            evt_vec[2*i+1] = !held_reg[i];
            evt_vec[2*i+2] = !kept_reg[i] && (prior_key_reg[i] != hkrd_pkg::CODE_CAPS);
        end
    end

    assign evt_rest = evt_vec >> pos_reg;
    assign pos_m1   = pos_reg - PW'(1);
    assign evt_slot = IW'(pos_m1 >> 1);

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        side_next      = side_reg;
        pos_next       = pos_reg;
        held_next      = held_reg;
        kept_next      = kept_reg;
        prior_mod_next = prior_mod_reg;
        commit         = 1'b0;
        caps_next      = caps_reg;
        num_next       = num_reg;
        scroll_next    = scroll_reg;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            hkrd_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = hkrd_pkg::ST_SCAN;
                    slot_next  = '0;
                    idx_next   = '0;
                    side_next  = 1'b0;
                    held_next  = '0;
                    kept_next  = '0;
                end
            end

            hkrd_pkg::ST_SCAN:
            begin
                if (cmp_hit)
                begin
                    if (side_reg)
                        kept_next[slot_reg] = 1'b1;
                    else
                        held_next[slot_reg] = 1'b1;
                end
                if (idx_reg == IW'(KEY_SLOTS - 1))
                begin
                    idx_next  = '0;
                    side_next = !side_reg;
                    if (side_reg)
                    begin
                        if (slot_reg == IW'(KEY_SLOTS - 1))
                        begin
                            state_next = hkrd_pkg::ST_EMIT;
                            pos_next   = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + IW'(1);
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            hkrd_pkg::ST_EMIT:
            begin
                if (!evt_vec[pos_reg] || !m_tvalid_reg || m_tready)
                begin
                    if (evt_vec[pos_reg])
                    begin
                        out_load      = 1'b1;
                        out_last_next = !(|evt_rest[NE-1:1]);
                        if (pos_reg == '0)
                        begin
                            out_kind_next = hkrd_pkg::KIND_MOD;
                            out_code_next = hkrd_pkg::CODE_NONE;
                        end
                        else if (!pos_m1[0])
                        begin
                            out_code_next = cur_key_reg[evt_slot];
                            out_kind_next = hkrd_pkg::KIND_DOWN;
                            if (cur_key_reg[evt_slot] == hkrd_pkg::CODE_CAPS)
                            begin
                                caps_next     = !caps_reg;
                                // caps press reports the new lock state
                                out_kind_next = caps_reg ? hkrd_pkg::KIND_UP
                                                         : hkrd_pkg::KIND_DOWN;
                            end
                            else if (cur_key_reg[evt_slot] == hkrd_pkg::CODE_NUM)
                                num_next = !num_reg;
                            else if (cur_key_reg[evt_slot] == hkrd_pkg::CODE_SCROLL)
                                scroll_next = !scroll_reg;
                        end
                        else
                        begin
                            out_kind_next = hkrd_pkg::KIND_UP;
                            out_code_next = prior_key_reg[evt_slot];
                        end
                    end
                    if (pos_reg == PW'(NE - 1))
                    begin
                        state_next     = hkrd_pkg::ST_IDLE;
                        prior_mod_next = cur_mod_reg;
                        commit         = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg + PW'(1);
                    end
                end
            end

            default:
            begin
                state_next = hkrd_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    // control and reset-defined state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hkrd_pkg::ST_IDLE;
            slot_reg      <= '0;
            idx_reg       <= '0;
            side_reg      <= 1'b0;
            pos_reg       <= '0;
            held_reg      <= '0;
            kept_reg      <= '0;
            prior_mod_reg <= '0;
            caps_reg      <= 1'b0;
            num_reg       <= 1'b0;
            scroll_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
                prior_key_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            idx_reg       <= idx_next;
            side_reg      <= side_next;
            pos_reg       <= pos_next;
            held_reg      <= held_next;
            kept_reg      <= kept_next;
            prior_mod_reg <= prior_mod_next;
            caps_reg      <= caps_next;
            num_reg       <= num_next;
            scroll_reg    <= scroll_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (commit)
            begin
                for (int i = 0; i < KEY_SLOTS; i++)
                    prior_key_reg[i] <= cur_key_reg[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cur_mod_reg <= s_tdata[CW-1:0];
            for (int i = 0; i < KEY_SLOTS; i++)
                cur_key_reg[i] <= s_tdata[CW*(i+1) +: CW];
        end
        if (out_load)
        begin
            out_kind_reg    <= out_kind_next;
            out_cur_reg     <= cur_mod_reg;
            out_earlier_reg <= prior_mod_reg;
            out_code_reg    <= out_code_next;
            out_caps_reg    <= caps_next;
            out_num_reg     <= num_next;
            out_scroll_reg  <= scroll_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'b00000, out_scroll_reg, out_num_reg, out_caps_reg, out_code_reg,
                       out_earlier_reg, out_cur_reg};

    // a report transaction always starts the matching pass
    `ASSERT_CLK(a_accept_starts_scan, (in_accept |=> state_reg == hkrd_pkg::ST_SCAN), "accepted report did not start matching")
    // modifier events never carry a key code
    `ASSERT_IMPL(a_mod_event_no_code, m_tvalid_reg && out_kind_reg == hkrd_pkg::KIND_MOD, out_code_reg == hkrd_pkg::CODE_NONE, "modifier event with key code")
    // the caps lock bit only moves together with an event load
    `ASSERT_CLK(a_caps_with_load, ((caps_reg != $past(caps_reg)) |-> $past(out_load)), "caps lock toggled without an event")
    // no event is loaded outside the output pass
    `ASSERT_IMPL(a_load_in_emit, out_load, state_reg == hkrd_pkg::ST_EMIT, "event loaded outside output pass")

endmodule

/* hw/rtl/hkrd_match.sv */
// shared code comparator of the report differ
// depends on hkrd_pkg
`timescale 1ns / 1ps

module hkrd_match
(
    input  logic [hkrd_pkg::CODE_WIDTH-1:0] code_a,
    input  logic [hkrd_pkg::CODE_WIDTH-1:0] code_b,
    output logic                            hit
);

    // code one is never reported as matched
    assign hit = (code_a == code_b) && (code_a != hkrd_pkg::CODE_NEVER_MATCH);

endmodule
